/* sv/smx_pkg.sv */
// Package for the stack machine executor: instruction and action codes,
// cell and count operations, and the decoder-to-datapath control struct.
// No dependencies.
package smx_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int DATA_W = 16;
   localparam int KIND_W = 4;
   localparam int ACTION_W = 4;
   localparam int STDIN_W = 9;
   localparam logic [STDIN_W-1:0] STDIN_NONE = '1;
   localparam int CHAR_W = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH      = 4'd0,
      KIND_ADD       = 4'd1,
      KIND_SUB       = 4'd2,
      KIND_EQ        = 4'd3,
      KIND_DUP       = 4'd4,
      KIND_POP       = 4'd5,
      KIND_JMP       = 4'd6,
      KIND_JIF       = 4'd7,
      KIND_PRINT     = 4'd8,
      KIND_PRINTCHAR = 4'd9,
      KIND_PRINTERR  = 4'd10,
      KIND_READ      = 4'd11,
      KIND_SYS       = 4'd12,
      KIND_SLEEP     = 4'd13,
      KIND_EXIT      = 4'd14
   } kind_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE  = 4'd0,
      ACT_JUMP  = 4'd1,
      ACT_PDEC  = 4'd2,
      ACT_PCHR  = 4'd3,
      ACT_PERR  = 4'd4,
      ACT_SYS   = 4'd5,
      ACT_SLEEP = 4'd6,
      ACT_EXIT  = 4'd7,
      ACT_OVER  = 4'd8,
      ACT_UNDER = 4'd9,
      ACT_HALT  = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP
   } cell_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      action_type        action;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] load_value;
      cell_op_type       top_op;
      cell_op_type       rest_op;
      cnt_op_type        cnt_op;
      logic              halt_set;
   } smx_ctrl_type;

endpackage

/* sv/smx_cell.sv */
// One stack cell: holds one entry and shifts toward or away from the top.
// Depends on smx_pkg.
module smx_cell
   import smx_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  cell_op_type       op,
   input  logic [DATA_W-1:0] up_data,
   input  logic [DATA_W-1:0] down_data,
   output logic [DATA_W-1:0] data_out
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (en) begin
         case (op)
            CELL_PUSH: data_in = up_data;
            CELL_POP:  data_in = down_data;
            default:   data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

/* sv/smx_decode.sv */
// Instruction decoder: checks stack bounds, computes the result action and
// the shift operations for the cell row. Depends on smx_pkg.
module smx_decode
   import smx_pkg::*;
(
   input  logic [KIND_W-1:0]  kind,
   input  logic [DATA_W-1:0]  immediate,
   input  logic [STDIN_W-1:0] stdin_value,
   input  logic [DATA_W-1:0]  top0,
   input  logic [DATA_W-1:0]  top1,
   input  logic               halted,
   input  logic               is_empty,
   input  logic               lt_two,
   input  logic               is_full,
   output smx_ctrl_type       ctrl
);

   logic need_two;
   logic need_one;
   logic grows;
   logic [DATA_W-1:0] read_value;

   always_comb begin
      need_two = 1'b0;
      need_one = 1'b0;
      grows    = 1'b0;
      case (kind_type'(kind))
         KIND_ADD, KIND_SUB, KIND_EQ:                 need_two = 1'b1;
         KIND_POP, KIND_JIF, KIND_PRINT, KIND_PRINTCHAR,
         KIND_PRINTERR, KIND_SYS, KIND_SLEEP:         need_one = 1'b1;
         KIND_PUSH, KIND_READ:                        grows    = 1'b1;
         KIND_DUP: begin
            need_one = 1'b1;
            grows    = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (stdin_value == STDIN_NONE) begin
         read_value = '0;
      end else begin
         read_value = DATA_W'($signed(stdin_value));
      end
   end

   always_comb begin
      ctrl.action     = ACT_NONE;
      ctrl.value      = '0;
      ctrl.load_value = '0;
      ctrl.top_op     = CELL_HOLD;
      ctrl.rest_op    = CELL_HOLD;
      ctrl.cnt_op     = CNT_HOLD;
      ctrl.halt_set   = 1'b0;
      if (halted) begin
         ctrl.action = ACT_HALT;
      end else if ((need_two && lt_two) || (need_one && is_empty)) begin
         ctrl.action   = ACT_UNDER;
         ctrl.halt_set = 1'b1;
      end else if (grows && is_full) begin
         ctrl.action   = ACT_OVER;
         ctrl.halt_set = 1'b1;
      end else begin
         case (kind_type'(kind))
            KIND_PUSH, KIND_DUP, KIND_READ: begin
               ctrl.top_op  = CELL_PUSH;
               ctrl.rest_op = CELL_PUSH;
               ctrl.cnt_op  = CNT_INC;
               if (kind_type'(kind) == KIND_PUSH) begin
                  ctrl.load_value = immediate;
               end else if (kind_type'(kind) == KIND_DUP) begin
                  ctrl.load_value = top0;
               end else begin
                  ctrl.load_value = read_value;
               end
            end
            KIND_ADD, KIND_SUB, KIND_EQ: begin
               ctrl.top_op  = CELL_PUSH;
               ctrl.rest_op = CELL_POP;
               ctrl.cnt_op  = CNT_DEC;
               if (kind_type'(kind) == KIND_ADD) begin
                  ctrl.load_value = top1 + top0;
               end else if (kind_type'(kind) == KIND_SUB) begin
                  ctrl.load_value = top1 - top0;
               end else begin
                  ctrl.load_value = DATA_W'(top1 == top0);
               end
            end
            KIND_JMP: begin
               ctrl.action = ACT_JUMP;
               ctrl.value  = immediate;
            end
            KIND_POP, KIND_JIF, KIND_PRINT, KIND_PRINTCHAR, KIND_PRINTERR,
            KIND_SYS, KIND_SLEEP: begin
               ctrl.top_op  = CELL_POP;
               ctrl.rest_op = CELL_POP;
               ctrl.cnt_op  = CNT_DEC;
               case (kind_type'(kind))
                  KIND_JIF: begin
                     if (top0 != '0) begin
                        ctrl.action = ACT_JUMP;
                        ctrl.value  = immediate;
                     end
                  end
                  KIND_PRINT: begin
                     ctrl.action = ACT_PDEC;
                     ctrl.value  = top0;
                  end
                  KIND_PRINTCHAR: begin
                     ctrl.action = ACT_PCHR;
                     ctrl.value  = DATA_W'(top0[CHAR_W-1:0]);
                  end
                  KIND_PRINTERR: begin
                     ctrl.action = ACT_PERR;
                     ctrl.value  = top0;
                  end
                  KIND_SYS: begin
                     ctrl.action = ACT_SYS;
                     ctrl.value  = top0;
                  end
                  KIND_SLEEP: begin
                     ctrl.action = ACT_SLEEP;
                     ctrl.value  = top0;
                  end
                  default: ;
               endcase
            end
            KIND_EXIT: begin
               ctrl.action   = ACT_EXIT;
               ctrl.halt_set = 1'b1;
            end
            default: ;
         endcase
      end
   end

endmodule

/* sv/stack_machine_executor_core.sv */
// Stack machine executor: one decoded 16-bit stack instruction per item.
// The operand stack is a row of STACK_DEPTH cells with the top entry in the
// first cell; push, pop and the two-operand instructions shift the whole row
// by one place in the same cycle. Each item's result is loaded into the output
// register at the edge that accepts it and is held there until it is taken on
// the rsp_ side. A new item is taken in the same cycle that the waiting result
// is taken, giving one instruction per clock while the rsp_ side stays ready.
// After exit, overflow or underflow every item answers halted until reset.
// Depends on smx_pkg, smx_decode and smx_cell.
module stack_machine_executor_core
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int COUNT_W = $clog2(STACK_DEPTH + 1)
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic [DATA_W-1:0]         req_immediate,
   input  logic signed [STDIN_W-1:0] req_stdin_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ACTION_W-1:0]       rsp_action,
   output logic signed [DATA_W-1:0]  rsp_action_value,
   output logic [COUNT_W-1:0]        rsp_entries_now
);

   smx_ctrl_type ctrl;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               halted_ff;
   logic               halted_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ACTION_W-1:0] rsp_action_ff;
   logic [DATA_W-1:0]  rsp_value_ff;
   logic [COUNT_W-1:0] rsp_entries_ff;
   logic               fire;

   logic [DATA_W-1:0] cell_q    [STACK_DEPTH];
   logic [DATA_W-1:0] cell_up   [STACK_DEPTH];
   logic [DATA_W-1:0] cell_down [STACK_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   smx_decode u_decode (
      .kind        (req_kind),
      .immediate   (req_immediate),
      .stdin_value (req_stdin_value),
      .top0        (cell_q[0]),
      .top1        (cell_q[1]),
      .halted      (halted_ff),
      .is_empty    (count_ff == '0),
      .lt_two      (count_ff < COUNT_W'(2)),
      .is_full     (count_ff >= COUNT_W'(STACK_DEPTH)),
      .ctrl        (ctrl)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign cell_up[i] = ctrl.load_value;
      end else begin : g_mid
         assign cell_up[i] = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign cell_down[i] = cell_q[i];
      end else begin : g_inner
         assign cell_down[i] = cell_q[i+1];
      end
      smx_cell u_cell (
         .clock     (clock),
         .en        (fire),
         .op        ((i == 0) ? ctrl.top_op : ctrl.rest_op),
         .up_data   (cell_up[i]),
         .down_data (cell_down[i]),
         .data_out  (cell_q[i])
      );
   end

   always_comb begin
      case (ctrl.cnt_op)
         CNT_INC: count_in = count_ff + COUNT_W'(1);
         CNT_DEC: count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase
      halted_in = halted_ff || ctrl.halt_set;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff  <= count_in;
            halted_ff <= halted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_action_ff  <= ctrl.action;
         rsp_value_ff   <= ctrl.value;
         rsp_entries_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_action_value = $signed(rsp_value_ff);
   assign rsp_entries_now  = rsp_entries_ff;

endmodule

/* sv/smx_checker.sv */
// Port-level checker for the stack machine executor, bound to the top level.
// Depends on smx_pkg and stack_machine_executor_core.
module smx_checker
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int COUNT_W = $clog2(STACK_DEPTH + 1)
)(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ACTION_W-1:0]       rsp_action,
   input logic signed [DATA_W-1:0]  rsp_action_value,
   input logic [COUNT_W-1:0]        rsp_entries_now
);

   logic terminal;
   logic quiet;

   assign terminal = (rsp_action == ACT_EXIT) || (rsp_action == ACT_OVER) ||
                     (rsp_action == ACT_UNDER) || (rsp_action == ACT_HALT);
   assign quiet    = terminal || (rsp_action == ACT_NONE);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
      $stable(rsp_action_value) && $stable(rsp_entries_now))
      else $error("result item changed while stalled");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && terminal |=> !rsp_valid || rsp_action == ACT_HALT)
      else $error("item after a terminating result was not halted");

   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && quiet |-> rsp_action_value == '0)
      else $error("nonzero value on a result without payload");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entries_now <= COUNT_W'(STACK_DEPTH))
      else $error("entry count beyond stack depth");

   a_halt_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && rsp_action == ACT_HALT
      |-> rsp_entries_now == $past(rsp_entries_now))
      else $error("halted result changed the entry count");

endmodule

bind stack_machine_executor_core smx_checker #(
   .STACK_DEPTH (STACK_DEPTH),
   .COUNT_W     (COUNT_W)
) u_smx_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_action       (rsp_action),
   .rsp_action_value (rsp_action_value),
   .rsp_entries_now  (rsp_entries_now)
);

/* bench/stack_machine_executor_core_test.sv */
// Testbench for stack_machine_executor_core: directed opening rows, random
// instruction streams under several idle patterns and a closing halt, checked
// against a predictor. Depends on smx_pkg and the RTL of the core only.
module stack_machine_executor_core_test
   import smx_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam int RANDOM_PER_PHASE = 390;
   localparam int HOLD_CYCLES = 80;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 4'd15;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DATA_W-1:0]   value;
      logic [6:0]          entries;
   } outcome_t;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DATA_W-1:0]  immediate;
      logic [STDIN_W-1:0] stdin;
      logic               typed;
      outcome_t           want;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [KIND_W-1:0] req_kind = '0;
   logic [DATA_W-1:0] req_immediate = '0;
   logic signed [STDIN_W-1:0] req_stdin_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ACTION_W-1:0] rsp_action;
   logic signed [DATA_W-1:0] rsp_action_value;
   logic [6:0] rsp_entries_now;

   logic row_typed = 1'b0;
   outcome_t row_want = '0;

   logic [DATA_W-1:0] stack_mem [DEPTH];
   int stack_len = 0;
   bit machine_halted = 1'b0;
   int fill_target = DEPTH;

   outcome_t expected_actions [$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_request = 1'b0;

   row_t opening_rows [28] = '{
      '{KIND_JMP,       16'hFFFF, 9'h000, 1'b1, '{ACT_JUMP, 16'hFFFF, 7'd0}},
      '{KIND_UNUSED,    16'h0000, 9'h000, 1'b1, '{ACT_NONE, 16'h0000, 7'd0}},
      '{KIND_READ,      16'h0000, 9'h1FF, 1'b1, '{ACT_NONE, 16'h0000, 7'd1}},
      '{KIND_READ,      16'hFFFF, 9'h0FF, 1'b0, '0},
      '{KIND_READ,      16'h0000, 9'h080, 1'b0, '0},
      '{KIND_EQ,        16'h0000, 9'h000, 1'b0, '0},
      '{KIND_JIF,       16'h1234, 9'h000, 1'b0, '0},
      '{KIND_PRINTCHAR, 16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'hFFFF, 9'h000, 1'b1, '{ACT_NONE, 16'h0000, 7'd1}},
      '{KIND_DUP,       16'h0000, 9'h000, 1'b0, '0},
      '{KIND_EQ,        16'h0000, 9'h000, 1'b0, '0},
      '{KIND_JIF,       16'h8000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'h0001, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'hFFFF, 9'h000, 1'b0, '0},
      '{KIND_ADD,       16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PRINT,     16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'h8000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'h0001, 9'h000, 1'b0, '0},
      '{KIND_SUB,       16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PRINTERR,  16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'h01FF, 9'h000, 1'b0, '0},
      '{KIND_PRINTCHAR, 16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'h003C, 9'h000, 1'b0, '0},
      '{KIND_SYS,       16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'hFFFF, 9'h000, 1'b0, '0},
      '{KIND_SLEEP,     16'h0000, 9'h000, 1'b0, '0},
      '{KIND_PUSH,      16'h1234, 9'h000, 1'b0, '0},
      '{KIND_POP,       16'h0000, 9'h000, 1'b0, '0}
   };

   stack_machine_executor_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_immediate    (req_immediate),
      .req_stdin_value  (req_stdin_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_action_value (rsp_action_value),
      .rsp_entries_now  (rsp_entries_now)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int operands_needed(input logic [KIND_W-1:0] k);
      case (k)
         KIND_ADD, KIND_SUB, KIND_EQ: return 2;
         KIND_DUP, KIND_POP, KIND_JIF, KIND_PRINT, KIND_PRINTCHAR, KIND_PRINTERR,
         KIND_SYS, KIND_SLEEP: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic bit grows_stack(input logic [KIND_W-1:0] k);
      return k == KIND_PUSH || k == KIND_DUP || k == KIND_READ;
   endfunction

   function automatic logic [DATA_W-1:0] pop_entry();
      stack_len--;
      return stack_mem[stack_len];
   endfunction

   function automatic void push_entry(input logic [DATA_W-1:0] v);
      stack_mem[stack_len] = v;
      stack_len++;
   endfunction

   function automatic outcome_t exec_instruction(input logic [KIND_W-1:0] k,
                                                 input logic [DATA_W-1:0] imm,
                                                 input logic [STDIN_W-1:0] sv);
      outcome_t o;
      logic [DATA_W-1:0] a, b;
      o = '0;
      o.action = ACT_NONE;
      if (machine_halted) begin
         o.action = ACT_HALT;
      end else if (stack_len < operands_needed(k)) begin
         machine_halted = 1'b1;
         o.action = ACT_UNDER;
      end else if (grows_stack(k) && stack_len >= DEPTH) begin
         machine_halted = 1'b1;
         o.action = ACT_OVER;
      end else begin
         case (k)
            KIND_PUSH: push_entry(imm);
            KIND_ADD: begin
               a = pop_entry();
               b = pop_entry();
               push_entry(a + b);
            end
            KIND_SUB: begin
               b = pop_entry();
               a = pop_entry();
               push_entry(a - b);
            end
            KIND_EQ: begin
               a = pop_entry();
               b = pop_entry();
               push_entry(DATA_W'(a == b));
            end
            KIND_DUP: push_entry(stack_mem[stack_len - 1]);
            KIND_POP: a = pop_entry();
            KIND_JMP: begin
               o.action = ACT_JUMP;
               o.value = imm;
            end
            KIND_JIF: begin
               a = pop_entry();
               if (a != '0) begin
                  o.action = ACT_JUMP;
                  o.value = imm;
               end
            end
            KIND_PRINT: begin
               o.action = ACT_PDEC;
               o.value = pop_entry();
            end
            KIND_PRINTCHAR: begin
               a = pop_entry();
               o.action = ACT_PCHR;
               o.value = {8'h00, a[CHAR_W-1:0]};
            end
            KIND_PRINTERR: begin
               o.action = ACT_PERR;
               o.value = pop_entry();
            end
            KIND_READ: push_entry(sv == STDIN_NONE ? '0 : {{(DATA_W-STDIN_W){sv[STDIN_W-1]}}, sv});
            KIND_SYS: begin
               o.action = ACT_SYS;
               o.value = pop_entry();
            end
            KIND_SLEEP: begin
               o.action = ACT_SLEEP;
               o.value = pop_entry();
            end
            KIND_EXIT: begin
               machine_halted = 1'b1;
               o.action = ACT_EXIT;
            end
            default: ;
         endcase
      end
      o.entries = 7'(stack_len);
      return o;
   endfunction

   function automatic logic [DATA_W-1:0] random_immediate();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return DATA_W'($urandom_range(0, 3));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [STDIN_W-1:0] random_stdin();
      if ($urandom_range(0, 3) == 0)
         return STDIN_NONE;
      return STDIN_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [KIND_W-1:0] grow_kind();
      case ($urandom_range(0, 2))
         0: return KIND_PUSH;
         1: return KIND_DUP;
         default: return KIND_READ;
      endcase
   endfunction

   // keep the machine running: no exit, no underflow, no overflow
   function automatic logic [KIND_W-1:0] pick_kind();
      logic [KIND_W-1:0] k;
      do begin
         if ($urandom_range(0, 4) == 0)
            k = KIND_W'($urandom_range(0, 15));
         else if (stack_len < fill_target)
            k = grow_kind();
         else
            k = KIND_W'($urandom_range(KIND_ADD, KIND_SLEEP));
      end while (k == KIND_EXIT || stack_len < operands_needed(k) ||
                 (grows_stack(k) && stack_len >= DEPTH));
      return k;
   endfunction

   task automatic report_mismatch(input string msg);
      if (errors < 40)
         $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic offer(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] imm,
                        input logic [STDIN_W-1:0] sv, input logic typed,
                        input outcome_t want);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_immediate <= imm;
      req_stdin_value <= sv;
      row_typed <= typed;
      row_want <= want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic offer_random();
      if (stack_len == fill_target) begin
         case ($urandom_range(0, 3))
            0: fill_target = 0;
            1: fill_target = DEPTH;
            default: fill_target = $urandom_range(0, DEPTH);
         endcase
      end
      offer(pick_kind(), random_immediate(), random_stdin(), 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_actions.size() != 0);
   endtask

   // one terminating event (overflow, underflow or exit), then halted answers
   task automatic end_with_halt();
      logic [KIND_W-1:0] k;
      case ($urandom_range(0, 2))
         0: begin
            while (stack_len < DEPTH)
               offer(KIND_PUSH, random_immediate(), random_stdin(), 1'b0, '0);
            k = grow_kind();
         end
         1: begin
            while (stack_len > 1)
               offer(KIND_POP, random_immediate(), random_stdin(), 1'b0, '0);
            if (stack_len == 1 && $urandom_range(0, 1)) begin
               k = KIND_W'(KIND_ADD + $urandom_range(0, 2));
            end else begin
               if (stack_len == 1)
                  offer(KIND_POP, random_immediate(), random_stdin(), 1'b0, '0);
               do k = KIND_W'($urandom_range(KIND_ADD, KIND_SLEEP));
               while (operands_needed(k) == 0);
            end
         end
         default: k = KIND_EXIT;
      endcase
      offer(k, random_immediate(), random_stdin(), 1'b0, '0);
      repeat (20)
         offer(KIND_W'($urandom_range(0, 15)), random_immediate(), random_stdin(), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      outcome_t want;
      outcome_t got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_action, rsp_action_value, rsp_entries_now};
            if (expected_actions.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: action %0d",
                                         rsp_action));
            end else begin
               want = expected_actions.pop_front();
               if (got.action !== want.action)
                  report_mismatch($sformatf("action %0d, expected %0d",
                                            got.action, want.action));
               if (got.value !== want.value)
                  report_mismatch($sformatf("action_value %h, expected %h",
                                            got.value, want.value));
               if (got.entries !== want.entries)
                  report_mismatch($sformatf("entries_now %0d, expected %0d",
                                            got.entries, want.entries));
            end
         end
         if (req_valid && req_ready) begin
            got = exec_instruction(req_kind, req_immediate, req_stdin_value);
            expected_actions.push_back(row_typed ? row_want : got);
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 24;
               recv_idle = 88;
            end
            1: begin
               send_idle = 88;
               recv_idle = 24;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
               hold_request = 1'b1;
            end
         endcase
         if (phase == 0) begin
            foreach (opening_rows[i])
               offer(opening_rows[i].kind, opening_rows[i].immediate, opening_rows[i].stdin,
                     opening_rows[i].typed, opening_rows[i].want);
         end
         repeat (RANDOM_PER_PHASE) offer_random();
         wait_drained();
      end
      end_with_halt();
      wait_drained();
      repeat (10) @(negedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
sv/smx_pkg.sv
sv/smx_cell.sv
sv/smx_decode.sv
sv/stack_machine_executor_core.sv
sv/smx_checker.sv
bench/stack_machine_executor_core_test.sv
